/* hw/rtl/hotness_ewma_wait_adapter_unit_assert.svh */
// ----------------------------------------------------------------------------
// hotness_ewma_wait_adapter_unit_assert.svh
// Assertion macros used by the checker file of the hotness adapter.
// ----------------------------------------------------------------------------
`ifndef HOTNESS_EWMA_WAIT_ADAPTER_UNIT_ASSERT_SVH
`define HOTNESS_EWMA_WAIT_ADAPTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HEWA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HEWA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/hewa_pkg.sv */
// ----------------------------------------------------------------------------
// hewa_pkg
// Types, register indexes and constants of the hotness EWMA wait adapter.
// ----------------------------------------------------------------------------
package hewa_pkg;

	localparam int COLOR_SLOTS_DEF = 64;

	localparam int COLOR_W = 6;
	localparam int Q16_W   = 16;
	localparam int WAIT_W  = 20;
	localparam int TALLY_W = 7;
	localparam int CIDX_W  = 3;

	localparam logic [Q16_W-1:0]   ALPHA_RESET = 16'd55706;
	localparam logic [Q16_W-1:0]   HOT_RESET   = 16'd62259;
	localparam logic [WAIT_W-1:0]  WAIT_RESET  = 20'd7000;
	localparam logic [WAIT_W-1:0]  WAIT_STEP   = 20'd1000;
	localparam logic [TALLY_W-1:0] TALLY_MAX   = 7'd127;
	localparam logic [TALLY_W-1:0] HOT_MIN     = 7'd2;
	localparam logic [1:0]         STREAK_CUT  = 2'd2;

	typedef enum logic [CIDX_W-1:0] {
		REG_ALPHA_RISE    = 3'd0,
		REG_ALPHA_FALL    = 3'd1,
		REG_HOT_LEVEL     = 3'd2,
		REG_ORIGINAL_WAIT = 3'd3,
		REG_HOLD_WAIT     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [Q16_W-1:0]  rise_wt;
		logic [Q16_W-1:0]  fall_wt;
		logic [Q16_W-1:0]  hot_level;
		logic [WAIT_W-1:0] original_wait;
		logic              hold_wait;
	} cfg_t;

	// Scan controller view handed back to the datapath.
	typedef struct packed {
		logic               first_scan;
		logic [TALLY_W-1:0] tally;
		logic [WAIT_W-1:0]  wait_us;
	} scan_stat_t;

endpackage

/* hw/rtl/hewa_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hewa_cfg_regs
// Configuration register file, written through its own valid/ready channel.
// ----------------------------------------------------------------------------
module hewa_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hewa_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [hewa_pkg::WAIT_W-1:0]  cfg_data,
	output hewa_pkg::cfg_t               cfg
);
	import hewa_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_wt       <= ALPHA_RESET;
			cfg_q.fall_wt       <= ALPHA_RESET;
			cfg_q.hot_level     <= HOT_RESET;
			cfg_q.original_wait <= WAIT_RESET;
			cfg_q.hold_wait     <= 1'b0;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_ALPHA_RISE:    cfg_q.rise_wt       <= cfg_data[Q16_W-1:0];
				REG_ALPHA_FALL:    cfg_q.fall_wt       <= cfg_data[Q16_W-1:0];
				REG_HOT_LEVEL:     cfg_q.hot_level     <= cfg_data[Q16_W-1:0];
				REG_ORIGINAL_WAIT: cfg_q.original_wait <= cfg_data;
				REG_HOLD_WAIT:     cfg_q.hold_wait     <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/hewa_avg_mem.sv */
// ----------------------------------------------------------------------------
// hewa_avg_mem
// Per-color average store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hewa_avg_mem #(
	parameter int DEPTH = hewa_pkg::COLOR_SLOTS_DEF,
	parameter int AW    = 6
) (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [hewa_pkg::Q16_W-1:0]  rd_data,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [hewa_pkg::Q16_W-1:0]  wr_data
);
	import hewa_pkg::*;

	logic [Q16_W-1:0] mem [DEPTH];
	logic [Q16_W-1:0] rd_data_q;

	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read-before-write on a same-address collision; the datapath bypasses it
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

/* hw/rtl/hewa_scan_ctl.sv */
// ----------------------------------------------------------------------------
// hewa_scan_ctl
// Scan bookkeeping: first-scan flag, hot tally, hot streak and wait adaption.
// ----------------------------------------------------------------------------
module hewa_scan_ctl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hewa_pkg::cfg_t        cfg,
	input  logic                  adv,
	input  logic                  last,
	input  logic                  hot,
	output hewa_pkg::scan_stat_t  stat
);
	import hewa_pkg::*;

	logic               first_q;
	logic [TALLY_W-1:0] tally_q;
	logic [1:0]         streak_q;
	logic [WAIT_W-1:0]  wait_q;

	logic               hot_inc;
	logic [TALLY_W-1:0] tally_nx;
	logic [1:0]         streak_tmp;
	logic [1:0]         streak_nx;
	logic [WAIT_W-1:0]  wait_nx;

	always_comb begin
		hot_inc  = !first_q && hot && (tally_q < TALLY_MAX);
		tally_nx = tally_q + TALLY_W'(hot_inc);
	end

	always_comb begin
		streak_tmp = 2'd0;
		streak_nx  = streak_q;
		wait_nx    = wait_q;
		if (last && !first_q && !cfg.hold_wait && (wait_q > WAIT_STEP)) begin
			if (tally_nx >= HOT_MIN) begin
				streak_tmp = streak_q + 2'd1;
			end
			if (streak_tmp >= STREAK_CUT) begin
				wait_nx   = wait_q - WAIT_STEP;
				streak_nx = 2'd0;
			end else begin
				streak_nx = streak_tmp;
				if (streak_tmp != 2'd0) begin
					wait_nx = cfg.original_wait;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			tally_q  <= '0;
			streak_q <= 2'd0;
			wait_q   <= WAIT_RESET;
		end else if (adv) begin
			streak_q <= streak_nx;
			wait_q   <= wait_nx;
			if (last) begin
				first_q <= 1'b0;
				tally_q <= '0;
			end else begin
				tally_q <= tally_nx;
			end
		end
	end

	assign stat.first_scan = first_q;
	assign stat.tally      = tally_nx;
	assign stat.wait_us    = wait_nx;

endmodule

/* hw/rtl/hotness_ewma_wait_adapter_unit.sv */
// ----------------------------------------------------------------------------
// hotness_ewma_wait_adapter_unit
// Per-color EWMA of eviction rates with hot-color counting and wait adaption.
// ----------------------------------------------------------------------------
// Takes one color rate per cycle while the output side is not stalled. The result
// of an item passes through the compute stage and the output register and is
// taken from the output register when the output side is free. Each item is a
// read-modify-write of the per-color average memory: the read is issued at
// acceptance, and the compute stage does the compare, one 17x17 multiply, the
// add and the write-back. A color repeated in the next item takes the
// just-written average through a bypass register, so there is no interlock.
// Stalls on the output side back up through the compute stage to in_ready.
// The average memory is not cleared; the first scan after reset writes every
// color it visits before any read of that color is used.
// ----------------------------------------------------------------------------
module hotness_ewma_wait_adapter_unit #(
	parameter int COLOR_SLOTS = hewa_pkg::COLOR_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [hewa_pkg::COLOR_W-1:0]  color,
	input  logic [hewa_pkg::Q16_W-1:0]    rate,
	input  logic                          last_color,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [hewa_pkg::COLOR_W-1:0]  color_out,
	output logic [hewa_pkg::Q16_W-1:0]    hotness,
	output logic                          scan_end,
	output logic [hewa_pkg::WAIT_W-1:0]   wait_us,
	output logic [hewa_pkg::TALLY_W-1:0]  hot_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hewa_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [hewa_pkg::WAIT_W-1:0]   cfg_data
);
	import hewa_pkg::*;

	localparam int AW = (COLOR_SLOTS > 1) ? $clog2(COLOR_SLOTS) : 1;

	cfg_t       cfg;
	scan_stat_t stat;

	logic          in_acc;
	logic [AW-1:0] in_slot;

	// compute stage
	logic               valid_s1;
	logic [COLOR_W-1:0] color_s1;
	logic [Q16_W-1:0]   rate_s1;
	logic               last_s1;
	logic [AW-1:0]      slot_s1;
	logic               byp_hit_s1;
	logic [Q16_W-1:0]   byp_data_s1;
	logic               adv_s1;

	logic [Q16_W-1:0]   rd_data;
	logic [Q16_W-1:0]   old_avg;
	logic [Q16_W-1:0]   alpha;
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic signed [33:0] acc;
	logic [Q16_W-1:0]   avg_new;
	logic               hot;

	// output register
	logic               out_valid_q;
	logic [COLOR_W-1:0] color_out_q;
	logic [Q16_W-1:0]   hotness_q;
	logic               scan_end_q;
	logic [WAIT_W-1:0]  wait_us_q;
	logic [TALLY_W-1:0] hot_count_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	// color folded onto the store through a constant lookup
	always_comb begin
		in_slot = '0;
		for (int i = 0; i < (1 << COLOR_W); i++) begin
			if (color == COLOR_W'(i)) begin
				in_slot = AW'(i % COLOR_SLOTS);
			end
		end
	end

	hewa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hewa_avg_mem #(
		.DEPTH (COLOR_SLOTS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (in_slot),
		.rd_data (rd_data),
		.wr_en   (adv_s1),
		.wr_addr (slot_s1),
		.wr_data (avg_new)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			color_s1    <= color;
			rate_s1     <= rate;
			last_s1     <= last_color;
			slot_s1     <= in_slot;
			// the memory returns the pre-write value when this edge also writes it
			byp_hit_s1  <= adv_s1 && (slot_s1 == in_slot);
			byp_data_s1 <= avg_new;
		end
	end

	// new = rate + a*(old - rate) / 2^16, floored; same as a*old + (1-a)*rate
	always_comb begin
		old_avg = byp_hit_s1 ? byp_data_s1 : rd_data;
		alpha   = (rate_s1 > old_avg) ? cfg.rise_wt : cfg.fall_wt;
		diff    = $signed({1'b0, old_avg}) - $signed({1'b0, rate_s1});
		prod    = $signed({1'b0, alpha}) * diff;
		acc     = $signed({2'b00, rate_s1, 16'h0000}) + prod;
		avg_new = stat.first_scan ? rate_s1 : acc[31:16];
		hot     = (avg_new >= cfg.hot_level);
	end

	hewa_scan_ctl u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv_s1),
		.last   (last_s1),
		.hot    (hot),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			color_out_q <= color_s1;
			hotness_q   <= avg_new;
			scan_end_q  <= last_s1;
			wait_us_q   <= stat.wait_us;
			hot_count_q <= stat.tally;
		end
	end

	assign out_valid = out_valid_q;
	assign color_out = color_out_q;
	assign hotness   = hotness_q;
	assign scan_end  = scan_end_q;
	assign wait_us   = wait_us_q;
	assign hot_count = hot_count_q;

endmodule

/* hw/rtl/hewa_checker.sv */
// ----------------------------------------------------------------------------
// hewa_checker
// Port-level checks of the hotness adapter, bound to the top level.
// ----------------------------------------------------------------------------
`include "hotness_ewma_wait_adapter_unit_assert.svh"

module hewa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hewa_pkg::COLOR_W-1:0]  color_out,
	input logic [hewa_pkg::Q16_W-1:0]    hotness,
	input logic                          scan_end,
	input logic [hewa_pkg::WAIT_W-1:0]   wait_us,
	input logic [hewa_pkg::TALLY_W-1:0]  hot_count,
	input logic                          cfg_valid,
	input logic                          cfg_ready
);
	import hewa_pkg::*;

	// a stalled result transaction holds its payload
	`HEWA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(hotness) && $stable(wait_us) && $stable(hot_count) && $stable(color_out) && $stable(scan_end), "result changed while stalled")

	// an empty output register always leaves room for a new item
	`HEWA_ASSERT_NOW(a_room, clk, arst_n, !out_valid, in_ready, "input blocked with output empty")

	// a fresh result follows an earlier input transaction
	`HEWA_ASSERT_NOW(a_latency, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a preceding input")

	// register writes are never back-pressured
	`HEWA_ASSERT_NOW(a_cfg_ready, clk, arst_n, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind hotness_ewma_wait_adapter_unit hewa_checker u_hewa_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hotness_ewma_wait_adapter_unit.
// ----------------------------------------------------------------------------
// Scans of color rates go in through a valid/ready channel. A shadow copy of
// the per-color averages, the hot tally, the streak and the wait gives the
// expected report for every accepted item. Reports are checked in order,
// field by field. Register settings change only while the unit is drained.
// Input idles and output stalls come at random, except in steady phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hewa_pkg::*;

	localparam int STALL_LIMIT = 1000;

	typedef struct {
		bit [COLOR_W-1:0] color_out;
		bit [Q16_W-1:0]   hotness;
		bit               scan_end;
		bit [WAIT_W-1:0]  wait_us;
		bit [TALLY_W-1:0] hot_count;
	} color_report_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [COLOR_W-1:0]  color = '0;
	logic [Q16_W-1:0]    rate = '0;
	logic                last_color = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [COLOR_W-1:0]  color_out;
	logic [Q16_W-1:0]    hotness;
	logic                scan_end;
	logic [WAIT_W-1:0]   wait_us;
	logic [TALLY_W-1:0]  hot_count;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index = '0;
	logic [WAIT_W-1:0]   cfg_data = '0;

	// shadow state of the unit
	cfg_t               shadow_cfg;
	bit [Q16_W-1:0]     avg_mem [COLOR_SLOTS_DEF];
	bit                 first_pass;
	bit [TALLY_W-1:0]   tally;
	bit [1:0]           streak;
	bit [WAIT_W-1:0]    cur_wait;

	color_report_t      awaited_reports [$];
	color_report_t      oldest;
	int                 mismatch_count = 0;
	int                 stuck_cycles = 0;
	bit                 steady = 1'b0;

	hotness_ewma_wait_adapter_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic color_report_t update_color_average(bit [COLOR_W-1:0] c,
			bit [Q16_W-1:0] r, bit last);
		color_report_t rep;
		bit [Q16_W-1:0] prev;
		bit [Q16_W-1:0] weight;
		bit [Q16_W-1:0] avg;
		bit [32:0]      acc;
		if (first_pass) begin
			avg = r;
		end else begin
			prev = avg_mem[c];
			weight = (r > prev) ? shadow_cfg.rise_wt : shadow_cfg.fall_wt;
			acc = 33'(weight) * 33'(prev) + (33'h10000 - 33'(weight)) * 33'(r);
			avg = acc[31:16];
			if (avg >= shadow_cfg.hot_level && tally < TALLY_MAX)
				tally++;
		end
		avg_mem[c] = avg;
		rep.color_out = c;
		rep.hotness = avg;
		rep.scan_end = last;
		rep.hot_count = tally;
		if (last) begin
			if (!first_pass && !shadow_cfg.hold_wait && cur_wait > WAIT_STEP) begin
				if (tally >= HOT_MIN)
					streak = streak + 2'd1;
				else
					streak = '0;
				if (streak >= STREAK_CUT) begin
					cur_wait = cur_wait - WAIT_STEP;
					streak = '0;
				end else if (streak != '0) begin
					cur_wait = shadow_cfg.original_wait;
				end
			end
			first_pass = 1'b0;
			tally = '0;
		end
		rep.wait_us = cur_wait;
		return rep;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// one input transaction; valid stays high into the next call unless it idles
	task automatic send_item(bit [COLOR_W-1:0] c, bit [Q16_W-1:0] r, bit last);
		int gap;
		gap = 0;
		if (!steady)
			while ($urandom_range(99) < 18) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		color <= c;
		rate <= r;
		last_color <= last;
		do @(posedge clk); while (!in_ready);
		awaited_reports.push_back(update_color_average(c, r, last));
	endtask

	// hold off input until every report is back
	task automatic settle();
		in_valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(cfg_t s);
		reg_idx_t order [5] = '{REG_ALPHA_RISE, REG_ALPHA_FALL, REG_HOT_LEVEL,
			REG_ORIGINAL_WAIT, REG_HOLD_WAIT};
		bit [WAIT_W-1:0] val;
		settle();
		foreach (order[k]) begin
			case (order[k])
				REG_ALPHA_RISE: val = WAIT_W'(s.rise_wt);
				REG_ALPHA_FALL: val = WAIT_W'(s.fall_wt);
				REG_HOT_LEVEL: val = WAIT_W'(s.hot_level);
				REG_ORIGINAL_WAIT: val = s.original_wait;
				default: val = WAIT_W'(s.hold_wait);
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= order[k];
			cfg_data <= val;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		shadow_cfg = s;
	endtask

	// whole scans with ascending colors, some out of order, rates leaning high
	task automatic run_scans(int n);
		int sent;
		int span;
		int pick;
		bit [COLOR_W-1:0] c;
		bit [COLOR_W-1:0] pc;
		bit [Q16_W-1:0] r;
		sent = 0;
		while (sent < n) begin
			span = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			c = COLOR_W'($urandom_range(63));
			for (int k = 0; k < span; k++) begin
				pick = $urandom_range(7);
				if (pick == 0)
					r = '0;
				else if (pick == 1)
					r = '1;
				else if (pick < 5)
					r = Q16_W'($urandom_range(56000, 65535));
				else
					r = Q16_W'($urandom_range(65535));
				pc = ($urandom_range(7) == 0) ? COLOR_W'($urandom_range(63)) : c;
				send_item(pc, r, k == span - 1);
				c = c + 1'b1;
				sent++;
			end
		end
	endtask

	// first scan after reset loads every color, so later reads all hit written entries
	task automatic test_first_scan();
		bit [Q16_W-1:0] r;
		for (int c = 0; c < COLOR_SLOTS_DEF; c++) begin
			if (c < 4 || c == 63)
				r = '1;
			else if (c == 4)
				r = '0;
			else
				r = Q16_W'($urandom_range(65535));
			send_item(COLOR_W'(c), r, c == COLOR_SLOTS_DEF - 1);
		end
	endtask

	// reset settings: restore, cut, cool scan, single hot color, rate equal to average
	task automatic test_directed_scans();
		repeat (2) begin
			send_item(6'd0, 16'hFFFF, 1'b0);
			send_item(6'd1, 16'hFFFF, 1'b0);
			send_item(6'd2, 16'hFFFF, 1'b1);
		end
		send_item(6'd0, 16'h0000, 1'b0);
		send_item(6'd1, 16'h0000, 1'b0);
		send_item(6'd2, 16'h0000, 1'b1);
		send_item(6'd3, 16'hFFFF, 1'b0);
		send_item(6'd4, 16'h0000, 1'b1);
		send_item(6'd63, 16'hFFFF, 1'b1);
		send_item(6'd62, 16'h8000, 1'b0);
		send_item(6'd63, 16'h7FFF, 1'b1);
	endtask

	task automatic test_hold_wait();
		cfg_t s;
		s.rise_wt = '0;
		s.fall_wt = '1;
		s.hot_level = '1;
		s.original_wait = '1;
		s.hold_wait = 1'b1;
		load_settings(s);
		run_scans(40);
	endtask

	task automatic test_random_settings();
		cfg_t s;
		s.rise_wt = Q16_W'($urandom_range(65535));
		s.fall_wt = Q16_W'($urandom_range(65535));
		s.hot_level = Q16_W'($urandom_range(50000, 65535));
		s.original_wait = WAIT_W'($urandom_range(1001, 1048575));
		s.hold_wait = 1'b0;
		load_settings(s);
		run_scans(60);
		steady = 1'b1;
		run_scans(30);
		steady = 1'b0;
		settle();
		run_scans(30);
	endtask

	// everything hot: one scan long enough to pin the tally, then short hot scans
	task automatic test_tally_saturation();
		cfg_t s;
		s.rise_wt = '1;
		s.fall_wt = '0;
		s.hot_level = '0;
		s.original_wait = '1;
		s.hold_wait = 1'b0;
		load_settings(s);
		for (int k = 0; k < 130; k++)
			send_item(COLOR_W'(k), Q16_W'($urandom_range(65535)), k == 129);
		repeat (4) begin
			send_item(COLOR_W'($urandom_range(63)), Q16_W'($urandom_range(65535)), 1'b0);
			send_item(COLOR_W'($urandom_range(63)), Q16_W'($urandom_range(65535)), 1'b1);
		end
	endtask

	// drive the wait to 500; from there it must never move again
	task automatic test_small_wait();
		cfg_t s;
		s.rise_wt = Q16_W'($urandom_range(65535));
		s.fall_wt = Q16_W'($urandom_range(65535));
		s.hot_level = '0;
		s.original_wait = WAIT_W'(1500);
		s.hold_wait = 1'b0;
		load_settings(s);
		repeat (6) begin
			send_item(COLOR_W'($urandom_range(63)), Q16_W'($urandom_range(65535)), 1'b0);
			send_item(COLOR_W'($urandom_range(63)), Q16_W'($urandom_range(65535)), 1'b1);
		end
		s.hot_level = Q16_W'($urandom_range(40000, 65535));
		s.original_wait = WAIT_W'(1);
		load_settings(s);
		run_scans(20);
	endtask

	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 18);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_reports.size() == 0) begin
				report_mismatch("report with nothing pending, color_out", color_out, 0);
			end else begin
				oldest = awaited_reports.pop_front();
				if (color_out !== oldest.color_out)
					report_mismatch("color_out", color_out, oldest.color_out);
				if (hotness !== oldest.hotness)
					report_mismatch("hotness", hotness, oldest.hotness);
				if (scan_end !== oldest.scan_end)
					report_mismatch("scan_end", scan_end, oldest.scan_end);
				if (wait_us !== oldest.wait_us)
					report_mismatch("wait_us", wait_us, oldest.wait_us);
				if (hot_count !== oldest.hot_count)
					report_mismatch("hot_count", hot_count, oldest.hot_count);
			end
		end
	end

	// watchdog: any transaction on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("** hotness_ewma_wait_adapter_unit: FAILED **");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		shadow_cfg.rise_wt = ALPHA_RESET;
		shadow_cfg.fall_wt = ALPHA_RESET;
		shadow_cfg.hot_level = HOT_RESET;
		shadow_cfg.original_wait = WAIT_RESET;
		shadow_cfg.hold_wait = 1'b0;
		first_pass = 1'b1;
		tally = '0;
		streak = '0;
		cur_wait = WAIT_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_scan();
		test_directed_scans();
		run_scans(50);
		test_hold_wait();
		test_random_settings();
		test_tally_saturation();
		test_small_wait();
		settle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("** hotness_ewma_wait_adapter_unit: PASSED **");
		else
			$display("** hotness_ewma_wait_adapter_unit: FAILED **");
		$finish;
	end

endmodule
